// ----- rtl/sklim_pkg.sv -----
// Shared constants and types for the soft-knee limiter with statistics.
package sklim_pkg;

	localparam int SAMPLE_W = 32;
	localparam int OUT_W    = 16;
	localparam int KNEE_W   = 15;
	localparam int PEAK_W   = 31;
	localparam int CNT_W    = 32;

	// Divider geometry: numerator 2*R*E + (E+R), divisor 2*(E+R), quotient <= R <= 2^15.
	localparam int NUM_W     = 48;
	localparam int DVS_W     = 33;
	localparam int QUO_W     = 17;
	localparam int DIV_CNT_W = 5;

	localparam logic [OUT_W-1:0]  POS_CEIL   = 16'd32767;
	localparam logic [OUT_W-1:0]  NEG_CEIL   = 16'd32768;
	localparam logic [KNEE_W-1:0] KNEE_RESET = 15'd30000;
	localparam logic [PEAK_W-1:0] PEAK_MAX   = 31'h7FFF_FFFF;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/sklim_div.sv -----
// Restoring divider, one quotient bit per cycle.
module sklim_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sklim_pkg::NUM_W-1:0]   numer,
	input  logic [sklim_pkg::DVS_W-1:0]   denom,
	output logic [sklim_pkg::QUO_W-1:0]   quo,
	output sklim_pkg::div_stat_t          stat
);
	import sklim_pkg::*;

	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [QUO_W-1:0]     nbits_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DVS_W:0]       rem_sh;
	logic                 fits;

	// top bits of the numerator start out below the divisor since quotient < 2^QUO_W
	always_comb begin
		rem_sh = {rem_q, nbits_q[QUO_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rem_q   <= '0;
			dvs_q   <= '0;
			nbits_q <= '0;
			quo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q   <= DVS_W'(numer[NUM_W-1:QUO_W]);
				nbits_q <= numer[QUO_W-1:0];
				dvs_q   <= denom;
				quo_q   <= '0;
				cnt_q   <= DIV_CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				rem_q   <= fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
				nbits_q <= {nbits_q[QUO_W-2:0], 1'b0};
				quo_q   <= {quo_q[QUO_W-2:0], fits};
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo       = quo_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

// ----- rtl/soft_knee_limiter_with_stats_unit.sv -----
// Soft-knee limiter: top level with sequencer, statistics and output register.
// A sample at or below the knee goes from accept through the finish state to the output;
//   a sample above the knee passes multiply, load, 17 divider steps and done before finish.
// One item is in work at a time; the 17-step restoring divider sets the pace.
// Input stall is high while an item is in work; a finished result waits in the
//   output register, so a new item can be taken before it is drained.
// Reset (arst_n low, asynchronous) clears state, counters, peak, output valid; knee = 30000.
module soft_knee_limiter_with_stats_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sklim_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sklim_pkg::OUT_W-1:0]  sample_out,
	output logic                                was_limited,
	output logic [sklim_pkg::PEAK_W-1:0]        peak_abs,
	output logic [sklim_pkg::CNT_W-1:0]         limited_total,
	output logic [sklim_pkg::CNT_W-1:0]         positive_total,
	output logic [sklim_pkg::CNT_W-1:0]         negative_total,
	input  logic                                cfg_we,
	input  logic [sklim_pkg::KNEE_W-1:0]        cfg_wdata
);
	import sklim_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [KNEE_W-1:0]   knee_q;
	logic [PEAK_W-1:0]   peak_q;
	logic [CNT_W-1:0]    lim_cnt_q;
	logic [CNT_W-1:0]    pos_cnt_q;
	logic [CNT_W-1:0]    neg_cnt_q;

	// per-item working registers
	logic                neg_q;
	logic                lim_q;
	logic [OUT_W-1:0]    pass_q;
	logic [OUT_W-1:0]    ceil_q;
	logic [OUT_W-1:0]    range_q;
	logic [SAMPLE_W-1:0] excess_q;
	logic [NUM_W-1:0]    prod_q;
	logic [SAMPLE_W-1:0] den_q;

	// output register
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_sample_q;
	logic                out_lim_q;
	logic [PEAK_W-1:0]   out_peak_q;
	logic [CNT_W-1:0]    out_lim_cnt_q;
	logic [CNT_W-1:0]    out_pos_cnt_q;
	logic [CNT_W-1:0]    out_neg_cnt_q;

	logic                accept;
	logic                neg;
	logic [SAMPLE_W-1:0] raw;
	logic [SAMPLE_W-1:0] mag;
	logic [PEAK_W-1:0]   mag31;
	logic                over;
	logic [OUT_W-1:0]    ceil;
	logic [NUM_W-1:0]    div_num;
	logic [DVS_W-1:0]    div_dvs;
	logic [QUO_W-1:0]    div_quo;
	div_stat_t           div_stat;
	logic [QUO_W-1:0]    shaped;
	logic [OUT_W-1:0]    capped;
	logic [OUT_W-1:0]    result;
	logic                out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		raw   = sample_in;
		neg   = raw[SAMPLE_W-1];
		// magnitude; the most negative sample maps to 2^31 in 32 unsigned bits
		mag   = neg ? (~raw + 32'd1) : raw;
		mag31 = mag[SAMPLE_W-1] ? PEAK_MAX : mag[PEAK_W-1:0];
		over  = mag > {17'd0, knee_q};
		ceil  = neg ? NEG_CEIL : POS_CEIL;
	end

	// rounding numerator 2*R*E + D over divisor 2*D, D = E + R
	always_comb begin
		div_num = {prod_q[NUM_W-2:0], 1'b0} + {16'd0, den_q};
		div_dvs = {den_q, 1'b0};
	end

	// knee + rounded quotient, capped at the ceiling, sign restored; unlimited samples pass through
	always_comb begin
		shaped = {2'b00, knee_q} + div_quo;
		capped = (shaped > {1'b0, ceil_q}) ? ceil_q : shaped[OUT_W-1:0];
		if (lim_q) begin
			result = neg_q ? (16'd0 - capped) : capped;
		end else begin
			result = pass_q;
		end
	end

	sklim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LOAD),
		.numer  (div_num),
		.denom  (div_dvs),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			knee_q        <= KNEE_RESET;
			peak_q        <= '0;
			lim_cnt_q     <= '0;
			pos_cnt_q     <= '0;
			neg_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
			out_sample_q  <= '0;
			out_lim_q     <= 1'b0;
			out_peak_q    <= '0;
			out_lim_cnt_q <= '0;
			out_pos_cnt_q <= '0;
			out_neg_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				knee_q <= cfg_wdata;
			end
			// drained and not refilled this cycle
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mag31 > peak_q) begin
							peak_q <= mag31;
						end
						if (over) begin
							lim_cnt_q <= lim_cnt_q + 1'b1;
							if (neg) begin
								neg_cnt_q <= neg_cnt_q + 1'b1;
							end else begin
								pos_cnt_q <= pos_cnt_q + 1'b1;
							end
						end
						state_q <= over ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_sample_q  <= result;
						out_lim_q     <= lim_q;
						out_peak_q    <= peak_q;
						out_lim_cnt_q <= lim_cnt_q;
						out_pos_cnt_q <= pos_cnt_q;
						out_neg_cnt_q <= neg_cnt_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q    <= neg;
			lim_q    <= over;
			pass_q   <= raw[OUT_W-1:0];
			ceil_q   <= ceil;
			range_q  <= ceil - {1'b0, knee_q};
			excess_q <= mag - {17'd0, knee_q};
		end
		if (state_q == ST_MUL) begin
			prod_q <= {32'd0, range_q} * {16'd0, excess_q};
			den_q  <= excess_q + {16'd0, range_q};
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_out     = out_sample_q;
	assign was_limited    = out_lim_q;
	assign peak_abs       = out_peak_q;
	assign limited_total  = out_lim_cnt_q;
	assign positive_total = out_pos_cnt_q;
	assign negative_total = out_neg_cnt_q;

endmodule

// ----- rtl/sklim_checker.sv -----
// Port-level assertions for the soft-knee limiter, bound to the top level.
module sklim_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [sklim_pkg::OUT_W-1:0]  sample_out,
	input logic [sklim_pkg::PEAK_W-1:0] peak_abs,
	input logic [sklim_pkg::CNT_W-1:0]  limited_total,
	input logic [sklim_pkg::CNT_W-1:0]  positive_total,
	input logic [sklim_pkg::CNT_W-1:0]  negative_total
);
	import sklim_pkg::*;

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous item in work");

	// peak only grows
	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		peak_abs >= $past(peak_abs))
		else $error("peak_abs decreased");

	// every limited item is either a positive or a negative overload
	a_count_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (limited_total == CNT_W'(positive_total + negative_total)))
		else $error("limited_total does not match positive + negative");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(sample_out)))
		else $error("stalled output item changed");

endmodule

bind soft_knee_limiter_with_stats_unit sklim_checker u_sklim_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.sample_out     (sample_out),
	.peak_abs       (peak_abs),
	.limited_total  (limited_total),
	.positive_total (positive_total),
	.negative_total (negative_total)
);

// ----- test/soft_knee_limiter_with_stats_unit_tb.sv -----
// Self-checking testbench for the soft-knee limiter with overload statistics.
module soft_knee_limiter_with_stats_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sklim_pkg::*;

	// Receiver hold-off length for the back-pressure test, in clock cycles.
	localparam int HOLD_CYCLES = 240;
	// Cycles to wait after the last result before ending: longer than the above-knee path.
	localparam int TAIL_CYCLES = 40;
	localparam logic [KNEE_W-1:0] KNEE_MAX = 15'd32767;

	// One limited sample plus the statistics reported with it.
	typedef struct {
		logic signed [OUT_W-1:0] sample;
		logic                    limited;
		logic [PEAK_W-1:0]       peak;
		logic [CNT_W-1:0]        limited_cnt;
		logic [CNT_W-1:0]        positive_cnt;
		logic [CNT_W-1:0]        negative_cnt;
	} limited_sample_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [OUT_W-1:0]    sample_out;
	logic                       was_limited;
	logic [PEAK_W-1:0]          peak_abs;
	logic [CNT_W-1:0]           limited_total;
	logic [CNT_W-1:0]           positive_total;
	logic [CNT_W-1:0]           negative_total;
	logic                       cfg_we;
	logic [KNEE_W-1:0]          cfg_wdata;

	// Shadow copy of the block's register and statistics.
	logic [KNEE_W-1:0] knee_now;
	logic [PEAK_W-1:0] peak_now;
	logic [CNT_W-1:0]  limited_now;
	logic [CNT_W-1:0]  positive_now;
	logic [CNT_W-1:0]  negative_now;

	// Limited samples predicted but not yet seen at the output, oldest first.
	limited_sample_t pending_samples[$];

	int mismatches;
	bit src_idle_on;
	bit sink_idle_on;
	int hold_seq;
	int hold_seen;
	int hold_left;

	soft_knee_limiter_with_stats_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_in      (sample_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample_out     (sample_out),
		.was_limited    (was_limited),
		.peak_abs       (peak_abs),
		.limited_total  (limited_total),
		.positive_total (positive_total),
		.negative_total (negative_total),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Limit the sample, update the shadow statistics, return what the block must report.
	function automatic limited_sample_t limit_sample(input logic [SAMPLE_W-1:0] raw);
		logic              neg;
		logic [32:0]       mag;
		logic [PEAK_W-1:0] mag_sat;
		longint unsigned   ceiling;
		longint unsigned   span;
		longint unsigned   excess;
		longint unsigned   den;
		longint unsigned   shaped;
		limited_sample_t   r;
		neg = raw[31];
		// Two's complement magnitude; -2^31 yields 2^31 in the 33-bit result.
		mag = neg ? ({1'b0, ~raw} + 33'd1) : {1'b0, raw};
		mag_sat = (mag > {2'b00, PEAK_MAX}) ? PEAK_MAX : mag[PEAK_W-1:0];
		if (mag_sat > peak_now) begin
			peak_now = mag_sat;
		end
		if (mag > {18'd0, knee_now}) begin
			limited_now = limited_now + 1;
			ceiling = neg ? 64'd32768 : 64'd32767;
			span = ceiling - knee_now;
			excess = mag - knee_now;
			den = excess + span;
			// knee + span*excess/(excess+span), rounded half up, capped at the ceiling
			shaped = knee_now + (2 * span * excess + den) / (2 * den);
			if (shaped > ceiling) begin
				shaped = ceiling;
			end
			if (neg) begin
				negative_now = negative_now + 1;
				r.sample = 16'd0 - shaped[15:0];
			end else begin
				positive_now = positive_now + 1;
				r.sample = shaped[15:0];
			end
			r.limited = 1'b1;
		end else begin
			r.sample = raw[15:0];
			r.limited = 1'b0;
		end
		r.peak = peak_now;
		r.limited_cnt = limited_now;
		r.positive_cnt = positive_now;
		r.negative_cnt = negative_now;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		mismatches++;
	endtask

	// Offer one item, starting at a falling edge; returns at the falling edge after
	// acceptance with in_valid still high, so back-to-back items keep valid asserted.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while (src_idle_on && $urandom_range(99) < 8) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample_in = value;
		do @(posedge clk); while (in_stall);
		pending_samples.push_back(limit_sample(value));
		@(negedge clk);
	endtask

	task automatic stop_input();
		in_valid = 1'b0;
	endtask

	// Sender pause: nothing goes in until every predicted item has come out.
	task automatic wait_drained();
		stop_input();
		while (pending_samples.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Knee writes happen only with the block empty; every item yields a result,
	// so an empty expectation queue means nothing is in flight.
	task automatic write_knee(input logic [KNEE_W-1:0] knee);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = knee;
		@(negedge clk);
		cfg_we = 1'b0;
		knee_now = knee;
	endtask

	// Mix of full-scale noise, values hugging the knee, 17-bit values and
	// magnitudes of random bit length, so every shaping region gets hit.
	function automatic logic [SAMPLE_W-1:0] random_sample();
		logic [SAMPLE_W-1:0] mag;
		logic                neg;
		neg = 1'($urandom_range(1));
		case ($urandom_range(4))
			0: return $urandom();
			1: mag = knee_now + $urandom_range(64) - 32;
			2: return $urandom_range(131071) - 65536;
			3: mag = $urandom() >> $urandom_range(31);
			default: begin
				// near the ceilings, where rounding hits the cap
				mag = 32'd32760 + $urandom_range(16);
			end
		endcase
		return neg ? (32'd0 - mag) : mag;
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_sample(random_sample());
		end
		stop_input();
	endtask

	// Field extremes at the reset knee: pass-through, knee edges, both ceilings,
	// full-scale values and the most negative input, which saturates the peak.
	task automatic test_reset_knee_extremes();
		logic [SAMPLE_W-1:0] values[$];
		values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd30000, 32'd30001, -32'sd30000,
			-32'sd30001, 32'd32767, -32'sd32768, 32'd32768, -32'sd32769, 32'd100000,
			-32'sd100000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_FFFF, 32'hFFFF_0000, 32'd12345};
		foreach (values[i]) begin
			send_sample(values[i]);
		end
		stop_input();
	endtask

	// Knee of zero (only zero passes), knee of one and the top knee, where the
	// negative side still has a step of one below its ceiling.
	task automatic test_knee_edges();
		write_knee(15'd0);
		send_sample(32'd0);
		send_sample(32'd1);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'd32767);
		send_sample(-32'sd32768);
		send_sample(32'h8000_0000);
		stop_input();
		write_knee(15'd1);
		send_sample(32'd1);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'd2);
		send_sample(-32'sd2);
		stop_input();
		write_knee(KNEE_MAX);
		send_sample(32'd32767);
		send_sample(32'd32768);
		send_sample(-32'sd32767);
		send_sample(-32'sd32768);
		send_sample(-32'sd32769);
		send_sample(32'h7FFF_FFFF);
		stop_input();
	endtask

	// Receiver holds off for a long stretch while items keep coming, so the
	// output register fills and the block has to stall its input.
	task automatic test_output_backpressure();
		write_knee(KNEE_W'($urandom_range(1, 32767)));
		hold_seq++;
		send_random(20);
		wait_drained();
	endtask

	// Random phases over several knees, one of them without any idling.
	task automatic test_random_phases();
		logic [KNEE_W-1:0] knees[$];
		knees = '{15'd30000, 15'd1, KNEE_MAX, 15'd0, 15'd0, 15'd0, 15'd0};
		for (int i = 4; i < knees.size(); i++) begin
			knees[i] = KNEE_W'($urandom_range(1, 32767));
		end
		foreach (knees[i]) begin
			write_knee(knees[i]);
			src_idle_on = (i != 4);
			sink_idle_on = (i != 4);
			send_random(knees[i] == 15'd0 ? 60 : 185);
		end
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// Receiver side: a pending hold request wins, else random stalls.
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= sink_idle_on && ($urandom_range(99) < 8);
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		limited_sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				report_mismatch("sample_out with no item pending", sample_out, 0);
			end else begin
				want = pending_samples.pop_front();
				if (sample_out !== want.sample)
					report_mismatch("sample_out", sample_out, want.sample);
				if (was_limited !== want.limited)
					report_mismatch("was_limited", was_limited, want.limited);
				if (peak_abs !== want.peak)
					report_mismatch("peak_abs", peak_abs, want.peak);
				if (limited_total !== want.limited_cnt)
					report_mismatch("limited_total", limited_total, want.limited_cnt);
				if (positive_total !== want.positive_cnt)
					report_mismatch("positive_total", positive_total, want.positive_cnt);
				if (negative_total !== want.negative_cnt)
					report_mismatch("negative_total", negative_total, want.negative_cnt);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		hold_seq = 0;
		hold_seen = 0;
		hold_left = 0;
		knee_now = KNEE_RESET;
		peak_now = '0;
		limited_now = '0;
		positive_now = '0;
		negative_now = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_knee_extremes();
		test_knee_edges();
		test_output_backpressure();
		test_random_phases();
		test_output_backpressure();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
